// File: hdl/iwc_pkg.sv
// shared constants, payload types and control structs of the intensity centroid block
`default_nettype none
package iwc_pkg;

	localparam int PIXEL_W     = 8;
	localparam int COL_COUNT_W = 11;
	localparam int TOTAL_W     = 28;
	localparam int WSUM_W      = 38;
	localparam int COORD_W     = 18;

	localparam logic [COL_COUNT_W-1:0] COL_COUNT_RESET = 11'd640;

	localparam int MAX_COLS_DEF      = 1024;
	localparam int MAX_ROWS_DEF      = 1024;
	localparam int FRACTION_BITS_DEF = 8;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               last_pixel;
	} pix_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] centroid_x;
		logic [COORD_W-1:0] centroid_y;
		logic               centroid_valid;
	} res_item_t;

	typedef struct packed {
		logic acc_en;
		logic div_load;
		logic div_sel_y;
		logic div_step;
		logic save_x;
		logic out_load;
	} iwc_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_busy;
	} iwc_stat_t;

endpackage
`default_nettype wire

// File: hdl/iwc_div.sv
// restoring divider, one quotient bit per cycle while step is high, saturating quotient
`default_nettype none
module iwc_div #(
	parameter int FRACTION_BITS = iwc_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire logic                        step,
	input  wire logic [iwc_pkg::WSUM_W-1:0]  wsum,
	input  wire logic [iwc_pkg::TOTAL_W-1:0] total,
	output logic                             done,
	output logic [iwc_pkg::COORD_W-1:0]      quotient
);
	import iwc_pkg::*;

	localparam int DVD_W = WSUM_W + FRACTION_BITS;
	localparam int LIM_W = TOTAL_W + COORD_W;
	localparam int EXT_W = (DVD_W > LIM_W) ? DVD_W : LIM_W;
	localparam int CNT_W = $clog2(COORD_W + 1);

	logic [EXT_W-1:0]   dvd_ext;
	logic [EXT_W-1:0]   lim_ext;
	logic [TOTAL_W:0]   rem_sh;
	logic               fits;
	logic [TOTAL_W-1:0] rem_q;
	logic [COORD_W-1:0] lo_q;
	logic [COORD_W-1:0] quo_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   cnt_q;

	always_comb begin
		dvd_ext = EXT_W'({wsum, {FRACTION_BITS{1'b0}}});
		lim_ext = EXT_W'({total, {COORD_W{1'b0}}});
		rem_sh  = {rem_q, lo_q[COORD_W-1]};
		fits    = rem_sh >= {1'b0, total};
	end

	// quotient that does not fit in the field (or zero divisor) flags overflow
	always_ff @(posedge clk) begin
		if (load) begin
			ovf_q <= dvd_ext >= lim_ext;
			rem_q <= TOTAL_W'(dvd_ext >> COORD_W);
			lo_q  <= dvd_ext[COORD_W-1:0];
			quo_q <= '0;
		end else if (step) begin
			rem_q <= fits ? TOTAL_W'(rem_sh - {1'b0, total}) : rem_sh[TOTAL_W-1:0];
			lo_q  <= {lo_q[COORD_W-2:0], 1'b0};
			quo_q <= {quo_q[COORD_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CNT_W'(COORD_W);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign done     = cnt_q == '0;
	assign quotient = ovf_q ? {COORD_W{1'b1}} : quo_q;

endmodule
`default_nettype wire

// File: hdl/iwc_datapath.sv
// accumulators, position counters, divider and result register
`default_nettype none
module iwc_datapath #(
	parameter int MAX_COLS      = iwc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS      = iwc_pkg::MAX_ROWS_DEF,
	parameter int FRACTION_BITS = iwc_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire iwc_pkg::iwc_cmd_t               cmd,
	output iwc_pkg::iwc_stat_t                   stat,
	input  wire iwc_pkg::pix_item_t              pix_data,
	input  wire logic                            cfg_we,
	input  wire logic [iwc_pkg::COL_COUNT_W-1:0] cfg_wdata,
	output logic                                 res_valid,
	input  wire logic                            res_ready,
	output iwc_pkg::res_item_t                   res_data
);
	import iwc_pkg::*;

	localparam int CW     = $clog2(MAX_COLS);
	localparam int RW     = $clog2(MAX_ROWS);
	localparam int PROD_W = PIXEL_W + ((CW > RW) ? CW : RW);
	localparam int WRAP_W = (CW + 1 > COL_COUNT_W) ? CW + 1 : COL_COUNT_W;

	logic [COL_COUNT_W-1:0] col_count_q;
	logic [TOTAL_W-1:0]     total_q;
	logic [WSUM_W-1:0]      col_sum_q;
	logic [WSUM_W-1:0]      row_sum_q;
	logic [CW-1:0]          col_q;
	logic [RW-1:0]          row_q;
	logic [COORD_W-1:0]     cx_q;
	logic                   res_valid_q;
	res_item_t              res_q;

	logic [PROD_W-1:0]  col_prod;
	logic [PROD_W-1:0]  row_prod;
	logic [TOTAL_W:0]   total_sum;
	logic [WSUM_W:0]    col_sum;
	logic [WSUM_W:0]    row_sum;
	logic [WRAP_W-1:0]  col_inc;
	logic               wrap;
	logic [WSUM_W-1:0]  div_wsum;
	logic               div_done;
	logic [COORD_W-1:0] div_quo;
	logic               nonzero;

	always_comb begin
		col_prod  = PROD_W'(pix_data.pixel) * PROD_W'(col_q);
		row_prod  = PROD_W'(pix_data.pixel) * PROD_W'(row_q);
		total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(pix_data.pixel);
		col_sum   = {1'b0, col_sum_q} + (WSUM_W + 1)'(col_prod);
		row_sum   = {1'b0, row_sum_q} + (WSUM_W + 1)'(row_prod);
		col_inc   = WRAP_W'(col_q) + WRAP_W'(1);
		// a row length of zero behaves as one; the column also wraps at the array width
		wrap      = (col_inc >= WRAP_W'(col_count_q)) || (col_q >= CW'(MAX_COLS - 1));
		div_wsum  = cmd.div_sel_y ? row_sum_q : col_sum_q;
		nonzero   = total_q != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= COL_COUNT_RESET;
		end else if (cfg_we) begin
			col_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			col_sum_q <= '0;
			row_sum_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else if (cmd.out_load) begin
			total_q   <= '0;
			col_sum_q <= '0;
			row_sum_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else if (cmd.acc_en) begin
			total_q   <= total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
			col_sum_q <= col_sum[WSUM_W] ? {WSUM_W{1'b1}} : col_sum[WSUM_W-1:0];
			row_sum_q <= row_sum[WSUM_W] ? {WSUM_W{1'b1}} : row_sum[WSUM_W-1:0];
			if (wrap) begin
				col_q <= '0;
				if (row_q < RW'(MAX_ROWS - 1)) begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	iwc_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (cmd.div_load),
		.step    (cmd.div_step),
		.wsum    (div_wsum),
		.total   (total_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.save_x) begin
			cx_q <= div_quo;
		end
		if (cmd.out_load) begin
			res_q.centroid_x     <= nonzero ? cx_q : '0;
			res_q.centroid_y     <= nonzero ? div_quo : '0;
			res_q.centroid_valid <= nonzero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign stat.div_done = div_done;
	assign stat.out_busy = res_valid_q && !res_ready;
	assign res_valid     = res_valid_q;
	assign res_data      = res_q;

endmodule
`default_nettype wire

// File: hdl/iwc_ctrl.sv
// frame controller: accumulate, two divisions, hand off the result
`default_nettype none
module iwc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pix_valid,
	input  wire logic               pix_last,
	output logic                    pix_ready,
	output iwc_pkg::iwc_cmd_t       cmd,
	input  wire iwc_pkg::iwc_stat_t stat
);
	import iwc_pkg::*;

	localparam logic [2:0] S_ACCUM  = 3'd0;
	localparam logic [2:0] S_LOAD_X = 3'd1;
	localparam logic [2:0] S_STEP_X = 3'd2;
	localparam logic [2:0] S_LOAD_Y = 3'd3;
	localparam logic [2:0] S_STEP_Y = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		pix_ready = 1'b0;
		unique case (state_q)
			S_ACCUM: begin
				pix_ready  = 1'b1;
				cmd.acc_en = pix_valid;
				if (pix_valid && pix_last) begin
					state_d = S_LOAD_X;
				end
			end
			S_LOAD_X: begin
				cmd.div_load = 1'b1;
				state_d      = S_STEP_X;
			end
			S_STEP_X: begin
				if (stat.div_done) begin
					cmd.save_x = 1'b1;
					state_d    = S_LOAD_Y;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_LOAD_Y: begin
				cmd.div_load  = 1'b1;
				cmd.div_sel_y = 1'b1;
				state_d       = S_STEP_Y;
			end
			S_STEP_Y: begin
				cmd.div_sel_y = 1'b1;
				if (stat.div_done) begin
					state_d = S_OUT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_OUT: begin
				// wait here while the previous result is still unclaimed
				cmd.div_sel_y = 1'b1;
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_ACCUM;
				end
			end
			default: begin
				state_d = S_ACCUM;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: hdl/intensity_weighted_centroid_unit.sv
// top level of the intensity-weighted centroid block
// Takes one 8-bit pixel per cycle in row-major order and accumulates the total intensity
// and the column- and row-weighted sums. A transfer with last_pixel set ends the frame:
// the input then stalls while one shared restoring divider, one quotient
// bit per cycle, produces centroid_x and then centroid_y (load, 18 steps and a done state
// each, then a load of the result register), longer if the previous result has
// not yet been taken. Coordinates are unsigned with FRACTION_BITS fraction bits, truncated
// and saturated at 2^18-1; a frame of zero intensity gives zero coordinates and clears
// centroid_valid. col_count may be written at any idle time and holds the row length.
`default_nettype none
module intensity_weighted_centroid_unit #(
	parameter int MAX_COLS      = iwc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS      = iwc_pkg::MAX_ROWS_DEF,
	parameter int FRACTION_BITS = iwc_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pix_valid,
	output logic                                 pix_ready,
	input  wire iwc_pkg::pix_item_t              pix_data,
	output logic                                 res_valid,
	input  wire logic                            res_ready,
	output iwc_pkg::res_item_t                   res_data,
	input  wire logic                            cfg_we,
	input  wire logic [iwc_pkg::COL_COUNT_W-1:0] cfg_wdata
);
	import iwc_pkg::*;

	iwc_cmd_t  cmd;
	iwc_stat_t stat;

	iwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_last (pix_data.last_pixel),
		.pix_ready(pix_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	iwc_datapath #(
		.MAX_COLS     (MAX_COLS),
		.MAX_ROWS     (MAX_ROWS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.pix_data (pix_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data)
	);

endmodule
`default_nettype wire

// File: hdl/iwc_checker.sv
// port-level checks of the centroid block and their binding to the top level
`default_nettype none
module iwc_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            pix_valid,
	input wire logic                            pix_ready,
	input wire iwc_pkg::pix_item_t              pix_data,
	input wire logic                            res_valid,
	input wire logic                            res_ready,
	input wire iwc_pkg::res_item_t              res_data,
	input wire logic                            cfg_we,
	input wire logic [iwc_pkg::COL_COUNT_W-1:0] cfg_wdata
);
	import iwc_pkg::*;

	logic cfg_seen;
	assign cfg_seen = cfg_we && (cfg_wdata == cfg_wdata);

	// an unclaimed result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed before its transfer");

	// empty frame reports zero coordinates
	a_zero_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.centroid_valid |->
			res_data.centroid_x == '0 && res_data.centroid_y == '0)
		else $error("invalid centroid with nonzero coordinates");

	// the end of a frame stalls the input during the divisions
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && pix_data.last_pixel |=> !pix_ready ##1 !pix_ready)
		else $error("pixel accepted during division");

	// a new result only appears after a stall of the input
	a_res_after_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!pix_ready) && !$past(cfg_seen && pix_ready))
		else $error("result without a preceding frame end");

endmodule

bind intensity_weighted_centroid_unit iwc_checker u_iwc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pix_valid(pix_valid),
	.pix_ready(pix_ready),
	.pix_data (pix_data),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res_data (res_data),
	.cfg_we   (cfg_we),
	.cfg_wdata(cfg_wdata)
);
`default_nettype wire
